// ===== rtl/prqs_pkg.sv =====
package prqs_pkg;

    // Fixed widths of the transaction fields.
    localparam int REQ_W    = 2;
    localparam int ID_W     = 5;
    localparam int LEVEL_W  = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT   = 2'd0,
        REQ_REMOVE   = 2'd1,
        REQ_SCHEDULE = 2'd2,
        REQ_IGNORE   = 2'd3
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_ALREADY   = 2'd1,
        ST_NOT_READY = 2'd2,
        ST_NOTHING   = 2'd3
    } status_t;

    typedef struct packed {
        req_kind_t            req_type;
        logic [ID_W-1:0]      thread_id;
        logic [LEVEL_W-1:0]   priority_level;
    } prqs_item_t;

    typedef struct packed {
        status_t              status;
        logic                 switched;
        logic                 prior_valid;
        logic [ID_W-1:0]      prior_thread;
        logic [ID_W-1:0]      chosen_thread;
        logic [LEVEL_W-1:0]   chosen_level;
    } prqs_result_t;

endpackage

// ===== rtl/prqs_req_if.sv =====
interface prqs_req_if;
    import prqs_pkg::*;

    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [ID_W-1:0]    thread_id;
    logic [LEVEL_W-1:0] priority_level;

    modport source (
        output valid,
        output req_type,
        output thread_id,
        output priority_level,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  thread_id,
        input  priority_level,
        output ready
    );

endinterface

// ===== rtl/prqs_rsp_if.sv =====
interface prqs_rsp_if;
    import prqs_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                switched;
    logic                prior_valid;
    logic [ID_W-1:0]     prior_thread;
    logic [ID_W-1:0]     chosen_thread;
    logic [LEVEL_W-1:0]  chosen_level;

    modport source (
        output valid,
        output status,
        output switched,
        output prior_valid,
        output prior_thread,
        output chosen_thread,
        output chosen_level,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  switched,
        input  prior_valid,
        input  prior_thread,
        input  chosen_thread,
        input  chosen_level,
        output ready
    );

endinterface

// ===== rtl/prqs_pick.sv =====
module prqs_pick #(
    parameter int NUM_LEVELS = 32
) (
    input  logic [NUM_LEVELS-1:0]         bitmap,
    output logic                          any,
    output logic [$clog2(NUM_LEVELS)-1:0] level
);
    localparam int LW = $clog2(NUM_LEVELS);

    // Lowest-numbered set bit wins; scanning from the top lets it land last.
    always_comb
    begin
        any   = |bitmap;
        level = '0;
        for (int i = NUM_LEVELS - 1; i >= 0; i--)
        begin
            if (bitmap[i])
            begin
                level = LW'(i);
            end
        end
    end

endmodule

// ===== rtl/prqs_queue.sv =====
module prqs_queue #(
    parameter int NUM_LEVELS  = 32,
    parameter int NUM_THREADS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  prqs_pkg::prqs_item_t   item,
    output prqs_pkg::prqs_result_t result
);
    import prqs_pkg::*;

    localparam int ID_SPAN = 1 << ID_W;
    localparam int NT      = (NUM_THREADS < ID_SPAN) ? NUM_THREADS : ID_SPAN;
    localparam int TW      = $clog2(NT);
    localparam int LW      = $clog2(NUM_LEVELS);

    // List storage. These hold nothing meaningful until written, so no reset.
    logic [TW-1:0] level_head_reg   [NUM_LEVELS];
    logic [TW-1:0] level_tail_reg   [NUM_LEVELS];
    logic [TW-1:0] next_link_reg    [NT];
    logic [TW-1:0] prev_link_reg    [NT];
    logic [LW-1:0] thread_level_reg [NT];

    logic [NUM_LEVELS-1:0] ready_bitmap_reg, ready_bitmap_next;
    logic [NT-1:0]         thread_ready_reg, thread_ready_next;
    logic [TW-1:0]         running_thread_reg, running_thread_next;
    logic                  running_valid_reg, running_valid_next;
    logic [LW-1:0]         running_level_reg, running_level_next;

    logic          tid_ok;
    logic [TW-1:0] tid;
    logic [LW-1:0] ins_lvl;
    logic [LW-1:0] cur_lvl;
    logic          pick_any;
    logic [LW-1:0] pick_lvl;
    logic [LW-1:0] head_ra, tail_ra;
    logic [TW-1:0] head_rd, tail_rd, next_rd, prev_rd;

    logic          head_we, tail_we, next_we, prev_we, tlvl_we;
    logic [LW-1:0] head_wa, tail_wa;
    logic [TW-1:0] head_wd, tail_wd, next_wa, next_wd, prev_wa, prev_wd;

    assign tid_ok  = 32'(item.thread_id) < 32'(NT);
    assign tid     = item.thread_id[TW-1:0];
    assign ins_lvl = (32'(item.priority_level) >= 32'(NUM_LEVELS)) ?
                     LW'(NUM_LEVELS - 1) : item.priority_level[LW-1:0];
    assign cur_lvl = thread_level_reg[tid];

    prqs_pick #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_pick (
        .bitmap (ready_bitmap_reg),
        .any    (pick_any),
        .level  (pick_lvl)
    );

    // One read address per table, chosen by the request kind.
    assign head_ra = (item.req_type == REQ_SCHEDULE) ? pick_lvl : cur_lvl;
    assign tail_ra = (item.req_type == REQ_INSERT) ? ins_lvl : cur_lvl;
    assign head_rd = level_head_reg[head_ra];
    assign tail_rd = level_tail_reg[tail_ra];
    assign next_rd = next_link_reg[tid];
    assign prev_rd = prev_link_reg[tid];

    always_comb
    begin
        result              = '0;
        result.status       = ST_OK;
        ready_bitmap_next   = ready_bitmap_reg;
        thread_ready_next   = thread_ready_reg;
        running_thread_next = running_thread_reg;
        running_valid_next  = running_valid_reg;
        running_level_next  = running_level_reg;
        head_we = 1'b0;
        head_wa = cur_lvl;
        head_wd = tid;
        tail_we = 1'b0;
        tail_wa = cur_lvl;
        tail_wd = tid;
        next_we = 1'b0;
        next_wa = tail_rd;
        next_wd = tid;
        prev_we = 1'b0;
        prev_wa = tid;
        prev_wd = tail_rd;
        tlvl_we = 1'b0;

        unique case (item.req_type)
            REQ_INSERT:
            begin
                if (!tid_ok)
                begin
                    result.status = ST_NOT_READY;
                end
                else if (thread_ready_reg[tid])
                begin
                    result.status = ST_ALREADY;
                end
                else
                begin
                    if (ready_bitmap_reg[ins_lvl])
                    begin
                        // Append behind the current tail.
                        next_we = 1'b1;
                        prev_we = 1'b1;
                    end
                    else
                    begin
                        head_we = 1'b1;
                        head_wa = ins_lvl;
                    end
                    tail_we = 1'b1;
                    tail_wa = ins_lvl;
                    tlvl_we = 1'b1;
                    thread_ready_next[tid]     = 1'b1;
                    ready_bitmap_next[ins_lvl] = 1'b1;
                end
            end
            REQ_REMOVE:
            begin
                if (!tid_ok || !thread_ready_reg[tid])
                begin
                    result.status = ST_NOT_READY;
                end
                else
                begin
                    priority if (head_rd == tid && tail_rd == tid)
                    begin
                        ready_bitmap_next[cur_lvl] = 1'b0;
                    end
                    else if (head_rd == tid)
                    begin
                        head_we = 1'b1;
                        head_wd = next_rd;
                    end
                    else if (tail_rd == tid)
                    begin
                        tail_we = 1'b1;
                        tail_wd = prev_rd;
                    end
                    else
                    begin
                        // Splice the neighbors together.
                        next_we = 1'b1;
                        next_wa = prev_rd;
                        next_wd = next_rd;
                        prev_we = 1'b1;
                        prev_wa = next_rd;
                        prev_wd = prev_rd;
                    end
                    thread_ready_next[tid] = 1'b0;
                end
            end
            REQ_SCHEDULE:
            begin
                if (!pick_any)
                begin
                    result.status = ST_NOTHING;
                end
                else
                begin
                    result.chosen_thread = ID_W'(head_rd);
                    if (!running_valid_reg || head_rd != running_thread_reg)
                    begin
                        result.switched     = 1'b1;
                        result.prior_valid  = running_valid_reg;
                        result.prior_thread = running_valid_reg ?
                                              ID_W'(running_thread_reg) : '0;
                        running_thread_next = head_rd;
                        running_valid_next  = 1'b1;
                        running_level_next  = pick_lvl;
                    end
                end
            end
            REQ_IGNORE:
            begin
                result.status = ST_OK;
            end
            default:
            begin
                result.status = ST_OK;
            end
        endcase

        result.chosen_level = LEVEL_W'(running_level_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_bitmap_reg   <= '0;
            thread_ready_reg   <= '0;
            running_thread_reg <= '0;
            running_valid_reg  <= 1'b0;
            running_level_reg  <= LW'(NUM_LEVELS - 1);
        end
        else if (step)
        begin
            ready_bitmap_reg   <= ready_bitmap_next;
            thread_ready_reg   <= thread_ready_next;
            running_thread_reg <= running_thread_next;
            running_valid_reg  <= running_valid_next;
            running_level_reg  <= running_level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && head_we)
        begin
            level_head_reg[head_wa] <= head_wd;
        end
        if (step && tail_we)
        begin
            level_tail_reg[tail_wa] <= tail_wd;
        end
        if (step && next_we)
        begin
            next_link_reg[next_wa] <= next_wd;
        end
        if (step && prev_we)
        begin
            prev_link_reg[prev_wa] <= prev_wd;
        end
        if (step && tlvl_we)
        begin
            thread_level_reg[tid] <= ins_lvl;
        end
    end

endmodule

// ===== rtl/priority_ready_queue_scheduler.sv =====
// Hardware ready queue for a real-time kernel. Each request transaction
// (insert a thread at a priority level, remove a thread, or schedule) yields
// exactly one response transaction. Every level keeps a FIFO of thread
// numbers as a doubly linked list, and a ready bitmap marks non-empty levels;
// a schedule picks the head of the lowest-numbered ready level and reports a
// switch when it differs from the running thread. Faults are reported in
// status: double insert (already ready), removing a thread that is not ready
// or is out of range (not ready), and scheduling with nothing ready. Priority
// levels at or beyond NUM_LEVELS saturate to the lowest priority, and thread
// numbers at or beyond NUM_THREADS are rejected. A request is latched in an
// input register and resolved into a response register once that register
// is free or is being emptied, and a new request is accepted every cycle as
// long as responses are taken; the throughput is one transaction per cycle,
// set by the single read-modify-write of the link tables held in flip-flops.
// There is no clearing pass after reset.
module priority_ready_queue_scheduler #(
    parameter int NUM_LEVELS  = 32,
    parameter int NUM_THREADS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    prqs_req_if.sink    req,
    prqs_rsp_if.source  rsp
);
    import prqs_pkg::*;

    // Input register: holds one accepted request until it is resolved.
    prqs_item_t   item_reg;
    logic         item_valid_reg, item_valid_next;

    // Response register: holds one finished result until it is taken.
    prqs_result_t result_reg;
    logic         rsp_valid_reg, rsp_valid_next;

    prqs_result_t result;
    logic         req_fire;
    logic         advance;

    // The held request resolves whenever the response register is free or
    // is being emptied in this same cycle; the queue state updates then.
    assign advance  = item_valid_reg && (!rsp_valid_reg || rsp.ready);
    // The input register takes a new request when it is empty or draining.
    assign req.ready = !item_valid_reg || advance;
    assign req_fire  = req.valid && req.ready;

    prqs_queue #(
        .NUM_LEVELS  (NUM_LEVELS),
        .NUM_THREADS (NUM_THREADS)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .result (result)
    );

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (req_fire)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers carry no reset; their valid flags qualify them.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            item_reg.req_type       <= req_kind_t'(req.req_type);
            item_reg.thread_id      <= req.thread_id;
            item_reg.priority_level <= req.priority_level;
        end
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.status        = result_reg.status;
    assign rsp.switched      = result_reg.switched;
    assign rsp.prior_valid   = result_reg.prior_valid;
    assign rsp.prior_thread  = result_reg.prior_thread;
    assign rsp.chosen_thread = result_reg.chosen_thread;
    assign rsp.chosen_level  = result_reg.chosen_level;

endmodule

// ===== tb/sv/tb_priority_ready_queue_scheduler.sv =====
`timescale 1ns / 1ps

// Self-checking testbench for the priority ready queue scheduler.
//
// Requests go in on the request channel and each accepted request transaction
// must produce exactly one response transaction. The testbench keeps its own
// copy of the ready queue: per-level linked lists, the ready bitmap and the
// running thread. It advances that copy in request acceptance order and
// queues the response it expects. Responses are matched in order against
// that queue, one field at a time.
//
// The run has two parts. A short directed table comes first. It covers reset
// behavior, the fault statuses, the first start, a switch, a
// reschedule of the running thread, and unlinking at head, tail, middle and
// sole member of a level. Then come four random phases with different idle
// and stall rates on the two channels.
module tb_priority_ready_queue_scheduler;

    import prqs_pkg::*;

    localparam int NUM_LEVELS  = 32;
    localparam int NUM_THREADS = 32;
    localparam int RANDOM_ITEMS_PER_PHASE = 100;

    // One row of the directed table. When typed is set, the response is
    // written out in the row because it is obvious from the request alone.
    // Otherwise the queue model supplies the expected response.
    typedef struct packed {
        prqs_item_t   item;
        bit           typed;
        prqs_result_t rsp;
    } directed_row_t;

    localparam prqs_result_t PREDICTED = '0;
    localparam int N_DIRECTED = 25;

    localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // Nothing is ready after reset, and the running level is the lowest.
        '{'{REQ_SCHEDULE, 5'd0, 5'd0}, 1'b1, '{ST_NOTHING, 1'b0, 1'b0, 5'd0, 5'd0, 5'd31}},
        '{'{REQ_REMOVE, 5'd0, 5'd0}, 1'b1, '{ST_NOT_READY, 1'b0, 1'b0, 5'd0, 5'd0, 5'd31}},
        '{'{REQ_IGNORE, 5'd31, 5'd31}, 1'b1, '{ST_OK, 1'b0, 1'b0, 5'd0, 5'd0, 5'd31}},
        '{'{REQ_INSERT, 5'd31, 5'd31}, 1'b1, '{ST_OK, 1'b0, 1'b0, 5'd0, 5'd0, 5'd31}},
        // A double insert is refused even with a different level.
        '{'{REQ_INSERT, 5'd31, 5'd0}, 1'b1, '{ST_ALREADY, 1'b0, 1'b0, 5'd0, 5'd0, 5'd31}},
        // The first start switches in with no previous thread.
        '{'{REQ_SCHEDULE, 5'd0, 5'd0}, 1'b1, '{ST_OK, 1'b1, 1'b0, 5'd0, 5'd31, 5'd31}},
        '{'{REQ_INSERT, 5'd0, 5'd0}, 1'b1, '{ST_OK, 1'b0, 1'b0, 5'd0, 5'd0, 5'd31}},
        '{'{REQ_INSERT, 5'd5, 5'd0}, 1'b0, PREDICTED},
        '{'{REQ_INSERT, 5'd7, 5'd0}, 1'b0, PREDICTED},
        '{'{REQ_SCHEDULE, 5'd0, 5'd0}, 1'b0, PREDICTED},
        // Scheduling again picks the running thread, so nothing switches.
        '{'{REQ_SCHEDULE, 5'd0, 5'd0}, 1'b0, PREDICTED},
        '{'{REQ_REMOVE, 5'd5, 5'd0}, 1'b0, PREDICTED},
        // The running thread leaves the queue from the head of its level.
        '{'{REQ_REMOVE, 5'd0, 5'd0}, 1'b0, PREDICTED},
        '{'{REQ_SCHEDULE, 5'd0, 5'd0}, 1'b0, PREDICTED},
        '{'{REQ_INSERT, 5'd5, 5'd0}, 1'b0, PREDICTED},
        '{'{REQ_REMOVE, 5'd5, 5'd0}, 1'b0, PREDICTED},
        '{'{REQ_REMOVE, 5'd7, 5'd0}, 1'b0, PREDICTED},
        '{'{REQ_SCHEDULE, 5'd0, 5'd0}, 1'b0, PREDICTED},
        '{'{REQ_INSERT, 5'd10, 5'd16}, 1'b0, PREDICTED},
        '{'{REQ_INSERT, 5'd11, 5'd16}, 1'b0, PREDICTED},
        '{'{REQ_REMOVE, 5'd31, 5'd0}, 1'b0, PREDICTED},
        '{'{REQ_SCHEDULE, 5'd0, 5'd0}, 1'b0, PREDICTED},
        '{'{REQ_REMOVE, 5'd10, 5'd0}, 1'b0, PREDICTED},
        '{'{REQ_REMOVE, 5'd11, 5'd0}, 1'b0, PREDICTED},
        // The queue is empty again, but a thread is still marked running.
        '{'{REQ_SCHEDULE, 5'd0, 5'd0}, 1'b0, PREDICTED}
    };

    logic clk;
    logic rst_n;

    prqs_req_if req_ch ();
    prqs_rsp_if rsp_ch ();

    priority_ready_queue_scheduler #(
        .NUM_LEVELS  (NUM_LEVELS),
        .NUM_THREADS (NUM_THREADS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // This copy of the ready queue holds the state after every request
    // accepted so far.
    logic [NUM_LEVELS-1:0]  ready_levels = '0;
    logic [LEVEL_W-1:0]     level_head [NUM_LEVELS];
    logic [LEVEL_W-1:0]     level_tail [NUM_LEVELS];
    logic [ID_W-1:0]        link_next [NUM_THREADS];
    logic [ID_W-1:0]        link_prev [NUM_THREADS];
    logic [LEVEL_W-1:0]     thread_lvl [NUM_THREADS];
    logic [NUM_THREADS-1:0] thread_queued = '0;
    logic [ID_W-1:0]        running_thread = '0;
    logic                   running_valid = 1'b0;
    logic [LEVEL_W-1:0]     running_level = LEVEL_W'(NUM_LEVELS - 1);

    prqs_result_t expected_rsps [$];
    int           fail_count = 0;

    // The driver sets these along with the request it offers.
    bit           row_typed = 1'b0;
    prqs_result_t row_rsp = '0;

    // Idle and stall rates, in percent, for the current phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int holdoff_left = 0;

    initial begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    initial begin
        #1000000;
        $display("TEST FAILED");
        $finish;
    end

    // Apply one request to the queue copy and return the response it
    // should produce.
    function automatic prqs_result_t advance_ready_queue(input prqs_item_t it);
        prqs_result_t    r;
        logic [ID_W-1:0] tid;
        logic [LEVEL_W-1:0] lvl;
        logic [ID_W-1:0] t;
        int              idx;
        r = '0;
        r.status = ST_OK;
        tid = it.thread_id;
        case (it.req_type)
            REQ_INSERT:
            begin
                if (int'(tid) >= NUM_THREADS) begin
                    r.status = ST_NOT_READY;
                end else if (thread_queued[tid]) begin
                    r.status = ST_ALREADY;
                end else begin
                    lvl = (int'(it.priority_level) >= NUM_LEVELS) ?
                          LEVEL_W'(NUM_LEVELS - 1) : it.priority_level;
                    // Append to the tail of a level that is already ready,
                    // or start a new list.
                    if (ready_levels[lvl]) begin
                        t = level_tail[lvl];
                        link_next[t] = tid;
                        link_prev[tid] = t;
                    end else begin
                        level_head[lvl] = tid;
                    end
                    level_tail[lvl] = tid;
                    thread_lvl[tid] = lvl;
                    thread_queued[tid] = 1'b1;
                    ready_levels[lvl] = 1'b1;
                end
            end
            REQ_REMOVE:
            begin
                if (int'(tid) >= NUM_THREADS || !thread_queued[tid]) begin
                    r.status = ST_NOT_READY;
                end else begin
                    lvl = thread_lvl[tid];
                    if (level_head[lvl] == tid && level_tail[lvl] == tid) begin
                        ready_levels[lvl] = 1'b0;
                    end else if (level_head[lvl] == tid) begin
                        level_head[lvl] = link_next[tid];
                    end else if (level_tail[lvl] == tid) begin
                        level_tail[lvl] = link_prev[tid];
                    end else begin
                        link_next[link_prev[tid]] = link_next[tid];
                        link_prev[link_next[tid]] = link_prev[tid];
                    end
                    thread_queued[tid] = 1'b0;
                end
            end
            REQ_SCHEDULE:
            begin
                if (ready_levels == '0) begin
                    r.status = ST_NOTHING;
                end else begin
                    idx = 0;
                    while (idx < NUM_LEVELS - 1 && !ready_levels[idx]) begin
                        idx++;
                    end
                    t = level_head[idx];
                    r.chosen_thread = t;
                    if (!running_valid || t != running_thread) begin
                        r.switched = 1'b1;
                        r.prior_valid = running_valid;
                        r.prior_thread = running_valid ? running_thread : '0;
                        running_thread = t;
                        running_valid = 1'b1;
                        running_level = LEVEL_W'(idx);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.chosen_level = running_level;
        return r;
    endfunction

    // Search from a random start for a thread whose queued flag matches.
    function automatic bit find_thread(input bit want_queued, output logic [ID_W-1:0] tid);
        int start;
        int k;
        start = $urandom_range(0, NUM_THREADS - 1);
        tid = '0;
        for (k = 0; k < NUM_THREADS; k++) begin
            if (thread_queued[(start + k) % NUM_THREADS] == want_queued) begin
                tid = ID_W'((start + k) % NUM_THREADS);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Most random requests make sense against the current queue, such as
    // inserting an idle thread or removing a queued one, so the lists grow
    // several entries deep. Some are schedules, and the rest are fully random
    // and produce double inserts, removes of idle threads and ignored request
    // types. Levels favor a few high priorities so that lists of more than one
    // entry form often.
    function automatic prqs_item_t next_random_request();
        prqs_item_t      it;
        int              roll;
        logic [ID_W-1:0] tid;
        roll = $urandom_range(0, 99);
        it.req_type = REQ_SCHEDULE;
        it.thread_id = ID_W'($urandom_range(0, NUM_THREADS - 1));
        it.priority_level = ($urandom_range(0, 99) < 70) ?
                            LEVEL_W'($urandom_range(0, 3)) :
                            LEVEL_W'($urandom_range(0, NUM_LEVELS - 1));
        if (roll < 15) begin
            it.req_type = req_kind_t'($urandom_range(0, 3));
        end else if (roll < 50) begin
            if (find_thread(1'b0, tid)) begin
                it.req_type = REQ_INSERT;
                it.thread_id = tid;
            end
        end else if (roll < 75) begin
            if (find_thread(1'b1, tid)) begin
                it.req_type = REQ_REMOVE;
                it.thread_id = tid;
            end
        end
        return it;
    endfunction

    // Offer one request starting at a falling edge, with a random idle gap
    // first. Returns at the falling edge after the transaction is accepted.
    task automatic send_request(input prqs_item_t it, input bit typed,
                                input prqs_result_t typed_rsp);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.req_type = it.req_type;
        req_ch.thread_id = it.thread_id;
        req_ch.priority_level = it.priority_level;
        row_typed = typed;
        row_rsp = typed_rsp;
        do begin
            @(posedge clk);
        end while (!req_ch.ready);
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected response has been taken.
    task automatic drain_responses();
        req_ch.valid = 1'b0;
        while (expected_rsps.size() != 0) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // The receiver changes ready at falling edges. A hold-off forces ready
    // low while its counter runs down. Otherwise ready follows the
    // stall rate of the current phase.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holdoff_left > 0) begin
                rsp_ch.ready = 1'b0;
                holdoff_left = holdoff_left - 1;
            end else begin
                rsp_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Both channels are observed in one process at the rising edge. A
    // request that is accepted pushes its expected response. A response
    // that is accepted is compared with the oldest expectation.
    always @(posedge clk) begin : observe
        prqs_item_t   acc_item;
        prqs_result_t want;
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                acc_item.req_type = req_kind_t'(req_ch.req_type);
                acc_item.thread_id = req_ch.thread_id;
                acc_item.priority_level = req_ch.priority_level;
                want = advance_ready_queue(acc_item);
                expected_rsps.push_back(row_typed ? row_rsp : want);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_rsps.size() == 0) begin
                    $error("response transaction with no request outstanding");
                    fail_count++;
                end else begin
                    want = expected_rsps.pop_front();
                    if (rsp_ch.status != want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.switched != want.switched) begin
                        $error("switched: expected %0d, actual %0d",
                               want.switched, rsp_ch.switched);
                        fail_count++;
                    end
                    if (rsp_ch.prior_valid != want.prior_valid) begin
                        $error("prior_valid: expected %0d, actual %0d",
                               want.prior_valid, rsp_ch.prior_valid);
                        fail_count++;
                    end
                    if (rsp_ch.prior_thread != want.prior_thread) begin
                        $error("prior_thread: expected %0d, actual %0d",
                               want.prior_thread, rsp_ch.prior_thread);
                        fail_count++;
                    end
                    if (rsp_ch.chosen_thread != want.chosen_thread) begin
                        $error("chosen_thread: expected %0d, actual %0d",
                               want.chosen_thread, rsp_ch.chosen_thread);
                        fail_count++;
                    end
                    if (rsp_ch.chosen_level != want.chosen_level) begin
                        $error("chosen_level: expected %0d, actual %0d",
                               want.chosen_level, rsp_ch.chosen_level);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int         i;
        int         phase;
        int         sent;
        prqs_item_t it;

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = REQ_INSERT;
        req_ch.thread_id = '0;
        req_ch.priority_level = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < N_DIRECTED; i++) begin
            send_request(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed,
                         DIRECTED_ROWS[i].rsp);
        end
        drain_responses();

        // Phase rates: no idling, idle sender, stalling receiver, and then
        // both at a light rate. The first phase opens with a long receiver
        // hold-off while the sender keeps going, so the block backs up and
        // stalls its request side.
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 54;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 54;
                end
                default:
                begin
                    send_idle_pct = 8;
                    recv_stall_pct = 8;
                end
            endcase
            if (phase == 0) begin
                @(posedge clk);
                holdoff_left = 64;
                @(negedge clk);
            end
            sent = 0;
            while (sent < RANDOM_ITEMS_PER_PHASE) begin
                it = next_random_request();
                send_request(it, 1'b0, PREDICTED);
                if (it.req_type != REQ_IGNORE) begin
                    sent++;
                end
            end
            // The sender waits here until every expected response is in.
            drain_responses();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0 && expected_rsps.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
